/* hw/rtl/strided_tensor_address_walker_unit_assert.svh */
// Assertion macros shared by the address walker RTL.
// Each macro takes a label, a clock, a synchronous reset and a property (an expression for STWALK_NEVER).
`ifndef STRIDED_TENSOR_ADDRESS_WALKER_UNIT_ASSERT_SVH
`define STRIDED_TENSOR_ADDRESS_WALKER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define STWALK_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("address walker check failed");
`define STWALK_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("address walker forbidden condition");
`else
`define STWALK_ASSERT(label, clk, rst, prop)
`define STWALK_NEVER(label, clk, rst, expr)
`endif
`endif

/* hw/rtl/stwalk_pkg.sv */
package stwalk_pkg;

   // Hardware dimension slots: index 0 is outer, the last is inner
   localparam int NUM_DIMS = 3;

   localparam int SIZE_W      = 13;
   localparam int STRIDE_W    = 16;
   localparam int BASE_W      = 24;
   localparam int ADDR_W      = 32;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 24;

   localparam int DIMS_DEFAULT         = 3;
   localparam int MAX_DIM_SIZE_DEFAULT = 4096;

   // Register map
   localparam logic [CSR_INDEX_W-1:0] REG_SIZE_OUTER    = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SIZE_MIDDLE   = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SIZE_INNER    = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_STRIDE_OUTER  = 8'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_STRIDE_MIDDLE = 8'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_STRIDE_INNER  = 8'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_BASE_OFFSET   = 8'd6;

   typedef struct packed {
      logic [NUM_DIMS-1:0][SIZE_W-1:0]   size;
      logic [NUM_DIMS-1:0][STRIDE_W-1:0] stride;
      logic [BASE_W-1:0]                 base;
   } cfg_type;

   // Only the innermost dims slots take part in the walk
   function automatic logic dim_active(input int d, input int dims);
      return d >= NUM_DIMS - dims;
   endfunction

   // Effective size: inactive slots and zero count as one, large sizes saturate
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] size,
                                                  input logic active,
                                                  input int unsigned max_size);
      logic [31:0] s;
      s = 32'(size);
      if (!active) begin
         s = 32'd1;
      end else if (s == 32'd0) begin
         s = 32'd1;
      end else if (s > max_size) begin
         s = max_size;
      end
      return SIZE_W'(s);
   endfunction

endpackage

/* hw/rtl/stwalk_odometer.sv */
module stwalk_odometer
   import stwalk_pkg::*;
#(
   parameter int DIMS         = DIMS_DEFAULT,
   parameter int MAX_DIM_SIZE = MAX_DIM_SIZE_DEFAULT
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           step,
   input  logic                                           restart,
   input  cfg_type                                        cfg,
   output logic [NUM_DIMS-1:0][$clog2(MAX_DIM_SIZE)-1:0]  idx_out,
   output logic                                           last_out
);

   localparam int CNT_W = $clog2(MAX_DIM_SIZE);

   logic [NUM_DIMS-1:0][CNT_W-1:0] cnt_ff;
   logic [NUM_DIMS-1:0][CNT_W-1:0] cnt_in;
   logic [NUM_DIMS-1:0][CNT_W-1:0] lim;
   logic [NUM_DIMS-1:0]            at_end;
   logic [NUM_DIMS-1:0][CNT_W-1:0] idx;
   logic [NUM_DIMS-1:0][CNT_W-1:0] idx_next;

   // Pick the indices for this transfer and find which dims sit at their end
   always_comb begin
      for (int d = 0; d < NUM_DIMS; d++) begin
         lim[d] = CNT_W'(eff_size(cfg.size[d], dim_active(d, DIMS), MAX_DIM_SIZE)
                         - SIZE_W'(1));
         if (restart || !dim_active(d, DIMS)) begin
            idx[d] = '0;
         end else begin
            idx[d] = cnt_ff[d];
         end
         at_end[d] = idx[d] >= lim[d];
      end
   end

   // Advance like an odometer, inner slot first; a carry wraps a slot to zero
   always_comb begin
      logic carry;
      carry = 1'b1;
      for (int d = NUM_DIMS - 1; d >= 0; d--) begin
         if (!dim_active(d, DIMS)) begin
            idx_next[d] = '0;
         end else if (carry) begin
            if (at_end[d]) begin
               idx_next[d] = '0;
            end else begin
               idx_next[d] = idx[d] + CNT_W'(1);
               carry       = 1'b0;
            end
         end else begin
            idx_next[d] = idx[d];
         end
      end
   end

   assign cnt_in   = step ? idx_next : cnt_ff;
   assign idx_out  = idx;
   assign last_out = &at_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

`include "strided_tensor_address_walker_unit_assert.svh"

   `STWALK_ASSERT(a_wrap_after_last, clock, reset, step && last_out |=> cnt_ff == '0)
   `STWALK_ASSERT(a_advance_nonzero, clock, reset, step && !last_out |=> cnt_ff != '0)
   `STWALK_ASSERT(a_hold_without_step, clock, reset, !step |=> $stable(cnt_ff))

endmodule

/* hw/rtl/strided_tensor_address_walker_unit.sv */
// Strided tensor address walker.
// Each transfer on the req_ channel asks for the next element address of a
// three-dimensional strided view, walked row-major with the inner dimension
// fastest. req_restart set clears the index counters before the address is
// formed. One rsp_ transfer comes back per request: the flat address
// (base + sum of index times stride), a last flag on the final element,
// after which the walk wraps to zero, and a contiguity flag for the layout.
// Registers are written on the csr_ channel, which is always ready; write
// only while no request is in flight.
// A request passes through three registered stages in order (index stage,
// multiply stage, sum stage) before rsp_valid rises. Throughput: one
// request per cycle while req_stall is low; the three stages drain
// independently, so a request is taken even while a finished response waits.
// When rsp_stall is held, the stages fill and req_stall rises once the index
// stage cannot move on.
// Reset: index counters clear, sizes and strides return to one, base to
// zero, and all stages empty.
module strided_tensor_address_walker_unit
   import stwalk_pkg::*;
#(
   parameter int DIMS         = DIMS_DEFAULT,
   parameter int MAX_DIM_SIZE = MAX_DIM_SIZE_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_restart,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [ADDR_W-1:0]      rsp_address,
   output logic                   rsp_last,
   output logic                   rsp_contiguous,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int CNT_W  = $clog2(MAX_DIM_SIZE);
   localparam int PROD_W = CNT_W + STRIDE_W;
   localparam int EXP_W  = 2 * SIZE_W;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   logic                           req_take;
   logic [NUM_DIMS-1:0][CNT_W-1:0] idx;
   logic                           idx_last;

   logic                            s1_valid_ff;
   logic                            s1_valid_in;
   logic [NUM_DIMS-1:0][CNT_W-1:0]  s1_idx_ff;
   logic                            s1_last_ff;
   logic                            s2_valid_ff;
   logic                            s2_valid_in;
   logic [NUM_DIMS-1:0][PROD_W-1:0] s2_prod_ff;
   logic                            s2_last_ff;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [ADDR_W-1:0]               rsp_address_ff;
   logic                            rsp_last_ff;
   logic                            rsp_contig_ff;

   logic                            contig_ff;
   logic                            contig_in;
   logic [NUM_DIMS-1:0][SIZE_W-1:0] esize;
   logic [EXP_W-1:0]                exp_outer;
   logic                            mis_inner;
   logic                            mis_middle;
   logic                            mis_outer;

   logic out_free;
   logic s2_free;
   logic s1_free;

   // Decode configuration writes
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index) inside
            REG_SIZE_OUTER, REG_SIZE_MIDDLE, REG_SIZE_INNER: begin
               cfg_in.size[csr_index[1:0]] = csr_data[SIZE_W-1:0];
            end
            REG_STRIDE_OUTER, REG_STRIDE_MIDDLE, REG_STRIDE_INNER: begin
               cfg_in.stride[2'(csr_index - REG_STRIDE_OUTER)] = csr_data[STRIDE_W-1:0];
            end
            REG_BASE_OFFSET: begin
               cfg_in.base = csr_data[BASE_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < NUM_DIMS; d++) begin
            cfg_ff.size[d]   <= SIZE_W'(1);
            cfg_ff.stride[d] <= STRIDE_W'(1);
         end
         cfg_ff.base <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Check for a dense row-major layout, inner slot outward
   always_comb begin
      for (int d = 0; d < NUM_DIMS; d++) begin
         esize[d] = eff_size(cfg_ff.size[d], dim_active(d, DIMS), MAX_DIM_SIZE);
      end
      exp_outer  = EXP_W'(esize[2]) * EXP_W'(esize[1]);
      mis_inner  = cfg_ff.stride[2] != STRIDE_W'(1);
      mis_middle = mis_inner || (cfg_ff.stride[1] != STRIDE_W'(esize[2]));
      mis_outer  = mis_middle || (EXP_W'(cfg_ff.stride[0]) != exp_outer);
      contig_in  = !((mis_inner && esize[2] != SIZE_W'(1)) ||
                     (mis_middle && esize[1] != SIZE_W'(1)) ||
                     (mis_outer && esize[0] != SIZE_W'(1)));
   end

   always_ff @(posedge clock) begin
      contig_ff <= contig_in;
   end

   // Stage flow: each stage moves when the one after it is empty or moving
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_stall = !s1_free;
   assign req_take  = req_valid && s1_free;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s2_free);
   assign s2_valid_in  = (s1_valid_ff && s2_free) || (s2_valid_ff && !out_free);
   assign rsp_valid_in = s2_valid_ff || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Index counters
   stwalk_odometer #(
      .DIMS         (DIMS),
      .MAX_DIM_SIZE (MAX_DIM_SIZE)
   ) u_odometer (
      .clock    (clock),
      .reset    (reset),
      .step     (req_take),
      .restart  (req_restart),
      .cfg      (cfg_ff),
      .idx_out  (idx),
      .last_out (idx_last)
   );

   // Capture indices of the accepted transfer
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_idx_ff  <= idx;
         s1_last_ff <= idx_last;
      end
   end

   // Form index times stride for each slot
   always_ff @(posedge clock) begin
      if (s1_valid_ff && s2_free) begin
         for (int d = 0; d < NUM_DIMS; d++) begin
            s2_prod_ff[d] <= PROD_W'(s1_idx_ff[d]) * PROD_W'(cfg_ff.stride[d]);
         end
         s2_last_ff <= s1_last_ff;
      end
   end

   // Sum into the response register
   always_ff @(posedge clock) begin
      if (s2_valid_ff && out_free) begin
         rsp_address_ff <= ADDR_W'(cfg_ff.base) + ADDR_W'(s2_prod_ff[0]) +
                           ADDR_W'(s2_prod_ff[1]) + ADDR_W'(s2_prod_ff[2]);
         rsp_last_ff    <= s2_last_ff;
         rsp_contig_ff  <= contig_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_address    = rsp_address_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_contiguous = rsp_contig_ff;

`include "strided_tensor_address_walker_unit_assert.svh"

   `STWALK_ASSERT(a_take_fills_s1, clock, reset, req_take |=> s1_valid_ff)
   `STWALK_ASSERT(a_stall_needs_s1, clock, reset, req_stall |-> s1_valid_ff && s2_valid_ff)
   `STWALK_ASSERT(a_s2_reaches_out, clock, reset, s2_valid_ff && out_free |=> rsp_valid_ff)

endmodule

/* dv/testbench.sv */
module testbench;
   import stwalk_pkg::*;

   localparam int WALK_DIMS     = DIMS_DEFAULT;
   localparam int DIM_LIMIT     = MAX_DIM_SIZE_DEFAULT;
   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 9;
   localparam int DRAIN_CYCLES  = 8;
   localparam int REPORT_LIMIT  = 10;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int ITEM_TARGET   = 700;
   localparam int HOLDOFF_SPAN  = 80;
   localparam int INDEX_W       = 12;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic              last;
      logic              contiguous;
   } element_type;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_stall;
   logic                   req_restart    = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall      = 1'b0;
   logic [ADDR_W-1:0]      rsp_address;
   logic                   rsp_last;
   logic                   rsp_contiguous;
   logic                   csr_valid      = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index      = '0;
   logic [CSR_DATA_W-1:0]  csr_data       = '0;

   // Shadow copy of the walker: registers and index counters
   logic [SIZE_W-1:0]   size_reg   [NUM_DIMS];
   logic [STRIDE_W-1:0] stride_reg [NUM_DIMS];
   logic [BASE_W-1:0]   base_reg;
   logic [INDEX_W-1:0]  walk_index [NUM_DIMS];

   element_type pending_elements [$];
   int          error_count   = 0;
   int          requests_sent = 0;
   int          cycle_count   = 0;
   bit          sender_eager  = 1'b0;

   // Long receiver hold-off, requested by a test and served by the stall driver
   int holdoff_requests = 0;
   int holdoff_served   = 0;
   int holdoff_len      = 0;
   int holdoff_left     = 0;
   int stall_run        = 0;
   bit stall_phase      = 1'b0;

   strided_tensor_address_walker_unit #(
      .DIMS         (WALK_DIMS),
      .MAX_DIM_SIZE (DIM_LIMIT)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_address    (rsp_address),
      .rsp_last       (rsp_last),
      .rsp_contiguous (rsp_contiguous),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Clamp a raw size register to the size the walk really uses
   function automatic int unsigned effective_size(input logic [SIZE_W-1:0] raw, input int d);
      int unsigned s;
      s = 32'(raw);
      if (d < NUM_DIMS - WALK_DIMS) return 1;
      if (s == 0) s = 1;
      if (s > DIM_LIMIT) s = DIM_LIMIT;
      return s;
   endfunction

   // Scan inner to outer; after the first stride break only unit sizes may follow
   function automatic logic layout_is_dense();
      longint unsigned step;
      logic            broken;
      logic            dense;
      int unsigned     s;
      step   = 1;
      broken = 1'b0;
      dense  = 1'b1;
      for (int d = NUM_DIMS - 1; d >= 0; d--) begin
         if (d >= NUM_DIMS - WALK_DIMS) begin
            s = effective_size(size_reg[d], d);
            if (64'(stride_reg[d]) != step) broken = 1'b1;
            if (broken && s != 1) dense = 1'b0;
            step = step * s;
         end
      end
      return dense;
   endfunction

   // Form the next element address, then advance the odometer
   function automatic element_type predict_element(input logic restart);
      element_type       elem;
      logic [ADDR_W-1:0] sum;
      logic              at_end;
      logic              carry;
      int unsigned       idx;
      int unsigned       s;
      if (restart) begin
         for (int d = 0; d < NUM_DIMS; d++) walk_index[d] = '0;
      end
      sum    = ADDR_W'(base_reg);
      at_end = 1'b1;
      for (int d = 0; d < NUM_DIMS; d++) begin
         idx = (d >= NUM_DIMS - WALK_DIMS) ? walk_index[d] : 0;
         s   = effective_size(size_reg[d], d);
         sum = sum + ADDR_W'(idx) * ADDR_W'(stride_reg[d]);
         if (idx < s - 1) at_end = 1'b0;
      end
      elem.address    = sum;
      elem.last       = at_end;
      elem.contiguous = layout_is_dense();
      carry = 1'b1;
      for (int d = NUM_DIMS - 1; d >= 0; d--) begin
         s = effective_size(size_reg[d], d);
         if (d < NUM_DIMS - WALK_DIMS) begin
            walk_index[d] = '0;
         end else if (carry) begin
            if (walk_index[d] < s - 1) begin
               walk_index[d] = walk_index[d] + 1'b1;
               carry = 1'b0;
            end else begin
               walk_index[d] = '0;
            end
         end
      end
      return elem;
   endfunction

   // Append one expectation at the tail of the pending list
   function automatic void queue_expected(input element_type elem);
      pending_elements = {pending_elements, elem};
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (sender_eager || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Size data: mostly small, some zero, some above the saturation point
   function automatic logic [CSR_DATA_W-1:0] pick_size_data();
      logic [CSR_DATA_W-1:0] data;
      int roll;
      data = CSR_DATA_W'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 75)      data[SIZE_W-1:0] = SIZE_W'($urandom_range(1, 4));
      else if (roll < 85) data[SIZE_W-1:0] = '0;
      else if (roll < 92) data[SIZE_W-1:0] = SIZE_W'($urandom_range(DIM_LIMIT + 1, 8191));
      else                data[SIZE_W-1:0] = SIZE_W'($urandom_range(5, DIM_LIMIT));
      return data;
   endfunction

   function automatic logic [STRIDE_W-1:0] pick_stride();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return STRIDE_W'($urandom);
      if (roll < 80) return STRIDE_W'($urandom_range(0, 8));
      if (roll < 90) return '1;
      return '0;
   endfunction

   // Drive one register transfer and mirror it in the shadow copy
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         REG_SIZE_OUTER:    size_reg[0]   = data[SIZE_W-1:0];
         REG_SIZE_MIDDLE:   size_reg[1]   = data[SIZE_W-1:0];
         REG_SIZE_INNER:    size_reg[2]   = data[SIZE_W-1:0];
         REG_STRIDE_OUTER:  stride_reg[0] = data[STRIDE_W-1:0];
         REG_STRIDE_MIDDLE: stride_reg[1] = data[STRIDE_W-1:0];
         REG_STRIDE_INNER:  stride_reg[2] = data[STRIDE_W-1:0];
         REG_BASE_OFFSET:   base_reg      = data[BASE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure_view(input logic [CSR_DATA_W-1:0] so, sm, si, to, tm, ti, base);
      write_csr(REG_SIZE_OUTER, so);
      write_csr(REG_SIZE_MIDDLE, sm);
      write_csr(REG_SIZE_INNER, si);
      write_csr(REG_STRIDE_OUTER, to);
      write_csr(REG_STRIDE_MIDDLE, tm);
      write_csr(REG_STRIDE_INNER, ti);
      write_csr(REG_BASE_OFFSET, base);
   endtask

   // Offer one request, hold it until the transfer, then record the expectation
   task automatic send_request(input logic restart);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      queue_expected(predict_element(restart));
      requests_sent++;
   endtask

   // Drop valid and wait until every expected element has come back
   task automatic wait_for_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_elements.size() != 0) @(posedge clock);
   endtask

   task automatic test_reset_state();
      send_request(1'b0);
      send_request(1'b1);
      wait_for_quiet();
   endtask

   // Dense 2x2x2 view walked through its end and one step into the wrap
   task automatic test_dense_walk();
      configure_view(24'd2, 24'd2, 24'd2, 24'd4, 24'd2, 24'd1, 24'd100);
      for (int i = 0; i < 9; i++) send_request(1'b0);
      wait_for_quiet();
   endtask

   // Zero and oversized sizes, maximum strides and base, ignored indexes
   task automatic test_register_corners();
      configure_view(24'h000000, 24'hFFFFFF, 24'h000003,
                     24'hFFFFFF, 24'h00FFFF, 24'h00FFFF, 24'hFFFFFF);
      write_csr(CSR_INDEX_W'(REG_BASE_OFFSET + 1), 24'h000000);
      write_csr('1, 24'hFFFFFF);
      send_request(1'b1);
      for (int i = 0; i < 4; i++) send_request(1'b0);
      wait_for_quiet();
      configure_view(24'd1, 24'd1, 24'd4096, 24'd0, 24'd0, 24'd0, 24'd0);
      send_request(1'b1);
      send_request(1'b0);
      wait_for_quiet();
   endtask

   // Shrink the inner size while its counter sits beyond the new end
   task automatic test_shrink_mid_walk();
      configure_view(24'd1, 24'd1, 24'd8, 24'd1, 24'd1, 24'd1, 24'h000010);
      send_request(1'b1);
      for (int i = 0; i < 5; i++) send_request(1'b0);
      wait_for_quiet();
      write_csr(REG_SIZE_INNER, 24'd3);
      for (int i = 0; i < 3; i++) send_request(1'b0);
      send_request(1'b1);
      wait_for_quiet();
   endtask

   // Hold off the receiver while the sender keeps offering, then drain
   task automatic test_output_holdoff();
      configure_view(24'd3, 24'd4, 24'd5, 24'd20, 24'd5, 24'd1, 24'h00ABCD);
      @(posedge clock);
      holdoff_len = HOLDOFF_SPAN;
      holdoff_requests++;
      sender_eager = 1'b1;
      for (int i = 0; i < 30; i++) send_request(1'b0);
      sender_eager = 1'b0;
      wait_for_quiet();
   endtask

   // Phases of random views, each walked mostly without restarts
   task automatic test_random_walks();
      logic [CSR_DATA_W-1:0] so, sm, si, to, tm, ti;
      logic [STRIDE_W-1:0]   dense_mid, dense_out;
      int unsigned           span;
      int                    items;
      int                    restart_pct;
      while (requests_sent < ITEM_TARGET) begin
         wait_for_quiet();
         so = pick_size_data();
         sm = pick_size_data();
         si = pick_size_data();
         to = CSR_DATA_W'($urandom);
         tm = CSR_DATA_W'($urandom);
         ti = CSR_DATA_W'($urandom);
         dense_mid = STRIDE_W'(effective_size(si[SIZE_W-1:0], 2));
         dense_out = STRIDE_W'(effective_size(si[SIZE_W-1:0], 2)
                               * effective_size(sm[SIZE_W-1:0], 1));
         if ($urandom_range(0, 1)) begin
            ti[STRIDE_W-1:0] = STRIDE_W'(1);
            tm[STRIDE_W-1:0] = dense_mid;
            to[STRIDE_W-1:0] = dense_out;
         end else begin
            ti[STRIDE_W-1:0] = pick_stride();
            tm[STRIDE_W-1:0] = pick_stride();
            to[STRIDE_W-1:0] = pick_stride();
         end
         if ($urandom_range(0, 9) == 0)
            write_csr(CSR_INDEX_W'($urandom_range(REG_BASE_OFFSET + 1, 255)),
                      CSR_DATA_W'($urandom));
         if ($urandom_range(0, 9) < 7) begin
            configure_view(so, sm, si, to, tm, ti, CSR_DATA_W'($urandom));
         end else begin
            if ($urandom_range(0, 1)) write_csr(REG_SIZE_OUTER, so);
            if ($urandom_range(0, 1)) write_csr(REG_SIZE_MIDDLE, sm);
            if ($urandom_range(0, 1)) write_csr(REG_SIZE_INNER, si);
            if ($urandom_range(0, 1)) write_csr(REG_STRIDE_OUTER, to);
            if ($urandom_range(0, 1)) write_csr(REG_STRIDE_MIDDLE, tm);
            if ($urandom_range(0, 1)) write_csr(REG_STRIDE_INNER, ti);
            if ($urandom_range(0, 1)) write_csr(REG_BASE_OFFSET, CSR_DATA_W'($urandom));
         end
         span = 1;
         for (int d = 0; d < NUM_DIMS; d++) begin
            span = span * effective_size(size_reg[d], d);
            if (span > 1000) span = 1000;
         end
         if (span <= 64) items = span * $urandom_range(1, 2) + $urandom_range(0, 4);
         else            items = $urandom_range(16, 48);
         restart_pct  = ($urandom_range(0, 9) == 0) ? 30 : 4;
         sender_eager = ($urandom_range(0, 3) == 0);
         send_request(1'($urandom_range(0, 1)));
         for (int i = 1; i < items; i++)
            send_request($urandom_range(0, 99) < restart_pct);
         sender_eager = 1'b0;
      end
   endtask

   // Receiver stall driver: served hold-off first, then random runs
   always @(negedge clock) begin
      if (holdoff_served != holdoff_requests) begin
         holdoff_served = holdoff_requests;
         holdoff_left   = holdoff_len;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (stall_run == 0) begin
            case ($urandom_range(0, 9)) inside
               [0:3]: begin
                  stall_phase = 1'b0;
                  stall_run   = $urandom_range(1, 20);
               end
               4: begin
                  stall_phase = 1'b0;
                  stall_run   = $urandom_range(40, 80);
               end
               9: begin
                  stall_phase = 1'b1;
                  stall_run   = $urandom_range(8, 30);
               end
               default: begin
                  stall_phase = 1'b1;
                  stall_run   = $urandom_range(1, 3);
               end
            endcase
         end
         stall_run--;
         rsp_stall <= stall_phase;
      end
   end

   // Compare each response transfer with the oldest expectation
   always @(posedge clock) begin
      element_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_elements.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected response: address %h last %b contiguous %b",
                        rsp_address, rsp_last, rsp_contiguous);
         end else begin
            want = pending_elements.pop_front();
            if (rsp_address !== want.address || rsp_last !== want.last
                || rsp_contiguous !== want.contiguous) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("mismatch: address %h/%h last %b/%b contiguous %b/%b (exp/got)",
                           want.address, rsp_address, want.last, rsp_last,
                           want.contiguous, rsp_contiguous);
            end
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      for (int d = 0; d < NUM_DIMS; d++) begin
         size_reg[d]   = SIZE_W'(1);
         stride_reg[d] = STRIDE_W'(1);
         walk_index[d] = '0;
      end
      base_reg = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_dense_walk();
      test_register_corners();
      test_shrink_mid_walk();
      test_output_holdoff();
      test_random_walks();

      wait_for_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_elements.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
